### sv/tilt_complementary_filter_defines.svh
// ----------------------------------------------------------------------------
// Tilt complementary filter assertion macros
// Shared concurrent assertion forms used by the filter's RTL.
// ----------------------------------------------------------------------------
`ifndef TILT_COMPLEMENTARY_FILTER_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_DEFINES_SVH

// same-cycle implication
`define TCF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/tcf_pkg.sv
// ----------------------------------------------------------------------------
// Tilt complementary filter package
// Widths, register codes, reset values and controller command types.
// ----------------------------------------------------------------------------
package tcf_pkg;

   localparam int Q_W        = 32;
   localparam int ALPHA_W    = 17;
   localparam int PERIOD_W   = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam int DIFF_W = 35;                         // blend difference s - x
   localparam int PROD_W = ALPHA_W + 1 + DIFF_W;       // shared multiplier output
   localparam int SUM_W  = PROD_W + 1;                 // blend sum before rounding
   localparam int RND_W  = SUM_W - 16;                 // after dropping 16 fraction bits

   localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = 17'd65536;
   localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 17'd64225;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd655;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLEND_ALPHA   = 4'd0,
      CSR_SAMPLE_PERIOD = 4'd1
   } tcf_csr_idx_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIFF_ANGLE,
      OP_ANGLE_OUT,
      OP_ACC,
      OP_DIFF_RATE,
      OP_RATE_OUT
   } tcf_op_type;

   typedef enum logic [1:0] {
      MSEL_NONE,
      MSEL_RATE,
      MSEL_ACCEL,
      MSEL_BLEND
   } tcf_msel_type;

   typedef struct packed {
      tcf_op_type   op;
      tcf_msel_type msel;
   } tcf_cmd_type;

endpackage

### sv/tcf_req_if.sv
// ----------------------------------------------------------------------------
// Tilt complementary filter request channel
// One sensor sample: angle, gyro rate and angular acceleration.
// ----------------------------------------------------------------------------
interface tcf_req_if import tcf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic signed [Q_W-1:0] angle_in;
   logic signed [Q_W-1:0] rate_in;
   logic signed [Q_W-1:0] accel_in;

   modport source (output valid, output angle_in, output rate_in, output accel_in,
                   input ready);
   modport sink   (input valid, input angle_in, input rate_in, input accel_in,
                   output ready);
endinterface

### sv/tcf_rsp_if.sv
// ----------------------------------------------------------------------------
// Tilt complementary filter response channel
// Filtered angle and filtered rate for one sample.
// ----------------------------------------------------------------------------
interface tcf_rsp_if import tcf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic signed [Q_W-1:0] angle_out;
   logic signed [Q_W-1:0] rate_out;

   modport source (output valid, output angle_out, output rate_out, input ready);
   modport sink   (input valid, input angle_out, input rate_out, output ready);
endinterface

### sv/tcf_csr_if.sv
// ----------------------------------------------------------------------------
// Tilt complementary filter register write channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface tcf_csr_if import tcf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/tcf_datapath.sv
// ----------------------------------------------------------------------------
// Tilt complementary filter datapath
// Config registers, filter state, one shared multiplier and the
// round/saturate adders, stepped by the controller's commands.
// ----------------------------------------------------------------------------
module tcf_datapath import tcf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  tcf_cmd_type           cmd,
   input  logic signed [Q_W-1:0] angle_in,
   input  logic signed [Q_W-1:0] rate_in,
   input  logic signed [Q_W-1:0] accel_in,
   input  logic                  csr_wr,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic signed [Q_W-1:0] angle_out,
   output logic signed [Q_W-1:0] rate_out
);

   // floor((x + 0.5 lsb) / 2^16): nearest, ties upwards
   function automatic logic signed [RND_W-1:0] rnd16(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-1:0] y;
      y = x + SUM_W'(32768);
      return y[SUM_W-1:16];
   endfunction

   function automatic logic signed [Q_W-1:0] sat32(input logic signed [RND_W-1:0] x);
      logic signed [RND_W-1:0] hi;
      logic signed [RND_W-1:0] lo;
      hi = RND_W'(signed'({1'b0, {(Q_W-1){1'b1}}}));
      lo = -hi - RND_W'(1);
      if (x > hi) begin
         return {1'b0, {(Q_W-1){1'b1}}};
      end else if (x < lo) begin
         return {1'b1, {(Q_W-1){1'b0}}};
      end
      return x[Q_W-1:0];
   endfunction

   logic [ALPHA_W-1:0]         alpha_ff;
   logic [PERIOD_W-1:0]        period_ff;
   logic signed [Q_W-1:0]      angle_ff, rate_ff, accel_ff;
   logic signed [Q_W-1:0]      prev_angle_ff, prev_rate_gyro_ff;
   logic signed [Q_W-1:0]      prev_rate_int_ff, prev_rate_filt_ff;
   logic                       first_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [DIFF_W-1:0]   diff_ff;
   logic signed [Q_W-1:0]      aout_ff, acc_ff;
   logic signed [Q_W-1:0]      angle_out_ff, rate_out_ff;

   logic [ALPHA_W-1:0]         alpha_eff;
   logic [ALPHA_W-1:0]         mul_a;
   logic signed [DIFF_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [RND_W-1:0]    prod_rnd;
   logic signed [RND_W-1:0]    blend_rnd;
   logic signed [Q_W-1:0]      blend_base;
   logic signed [RND_W-1:0]    diff_wide;

   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.msel)
         MSEL_RATE: begin
            mul_a = {1'b0, period_ff};
            mul_b = DIFF_W'(rate_ff);
         end
         MSEL_ACCEL: begin
            mul_a = {1'b0, period_ff};
            mul_b = DIFF_W'(accel_ff);
         end
         MSEL_BLEND: begin
            mul_a = alpha_eff;
            mul_b = diff_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = signed'({1'b0, mul_a}) * mul_b;
   assign prod_rnd = rnd16(SUM_W'(prod_ff));

   // blend = x*2^16 + alpha*(s - x), x being the angle or the integrated rate
   assign blend_base = (cmd.op == OP_ANGLE_OUT) ? angle_ff : acc_ff;
   assign blend_rnd  = rnd16((SUM_W'(blend_base) <<< 16) + SUM_W'(prod_ff));

   always_comb begin
      diff_wide = '0;
      unique case (cmd.op)
         OP_DIFF_ANGLE: diff_wide = RND_W'(prev_angle_ff) + prod_rnd - RND_W'(angle_ff);
         OP_DIFF_RATE:  diff_wide = RND_W'(prev_rate_filt_ff) + RND_W'(rate_ff)
                                    + RND_W'(prev_rate_gyro_ff) - RND_W'(acc_ff);
         default:       diff_wide = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff          <= ALPHA_RESET;
         period_ff         <= PERIOD_RESET;
         prev_angle_ff     <= '0;
         prev_rate_gyro_ff <= '0;
         prev_rate_int_ff  <= '0;
         prev_rate_filt_ff <= '0;
         first_ff          <= 1'b1;
      end else begin
         if (csr_wr) begin
            if (csr_index == CSR_BLEND_ALPHA) begin
               alpha_ff <= csr_data[ALPHA_W-1:0];
            end else if (csr_index == CSR_SAMPLE_PERIOD) begin
               period_ff <= csr_data[PERIOD_W-1:0];
            end
         end
         if (cmd.op == OP_LOAD && first_ff) begin
            first_ff          <= 1'b0;
            prev_angle_ff     <= angle_in;
            prev_rate_gyro_ff <= rate_in;
            prev_rate_int_ff  <= rate_in;
            prev_rate_filt_ff <= rate_in;
         end
         if (cmd.op == OP_RATE_OUT) begin
            prev_angle_ff     <= aout_ff;
            prev_rate_int_ff  <= acc_ff;
            prev_rate_gyro_ff <= rate_ff;
            prev_rate_filt_ff <= sat32(blend_rnd);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.msel != MSEL_NONE) begin
         prod_ff <= prod_in;
      end
      unique case (cmd.op)
         OP_LOAD: begin
            angle_ff <= angle_in;
            rate_ff  <= rate_in;
            accel_ff <= accel_in;
         end
         OP_DIFF_ANGLE, OP_DIFF_RATE: begin
            diff_ff <= diff_wide[DIFF_W-1:0];
         end
         OP_ANGLE_OUT: begin
            aout_ff <= sat32(blend_rnd);
         end
         OP_ACC: begin
            acc_ff <= sat32(RND_W'(prev_rate_int_ff) + prod_rnd);
         end
         OP_RATE_OUT: begin
            angle_out_ff <= aout_ff;
            rate_out_ff  <= sat32(blend_rnd);
         end
         default: begin
         end
      endcase
   end

   assign angle_out = angle_out_ff;
   assign rate_out  = rate_out_ff;

endmodule

### sv/tcf_ctrl.sv
// ----------------------------------------------------------------------------
// Tilt complementary filter controller
// Sequences one sample through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
`include "tilt_complementary_filter_defines.svh"

module tcf_ctrl import tcf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output tcf_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_RATE,
      ST_DIFF_ANGLE,
      ST_MUL_ANGLE,
      ST_ANGLE_OUT,
      ST_ACC,
      ST_DIFF_RATE,
      ST_MUL_RATE_BL,
      ST_RATE_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '{op: OP_NONE, msel: MSEL_NONE};
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_MUL_RATE;
            end
         end
         ST_MUL_RATE: begin
            cmd.msel = MSEL_RATE;
            state_in = ST_DIFF_ANGLE;
         end
         ST_DIFF_ANGLE: begin
            cmd.op   = OP_DIFF_ANGLE;
            state_in = ST_MUL_ANGLE;
         end
         ST_MUL_ANGLE: begin
            cmd.msel = MSEL_BLEND;
            state_in = ST_ANGLE_OUT;
         end
         ST_ANGLE_OUT: begin
            cmd.op   = OP_ANGLE_OUT;
            cmd.msel = MSEL_ACCEL;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op   = OP_ACC;
            state_in = ST_DIFF_RATE;
         end
         ST_DIFF_RATE: begin
            cmd.op   = OP_DIFF_RATE;
            state_in = ST_MUL_RATE_BL;
         end
         ST_MUL_RATE_BL: begin
            cmd.msel = MSEL_BLEND;
            state_in = ST_RATE_OUT;
         end
         ST_RATE_OUT: begin
            // hold until the response register is free
            if (out_free) begin
               cmd.op       = OP_RATE_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TCF_ASSERT_NEXT(a_busy_after_request, clock, reset, req_valid && req_ready, !req_ready, "request accepted while busy")
   `TCF_ASSERT_IMPLY(a_commit_needs_room, clock, reset, cmd.op == OP_RATE_OUT, !rsp_valid_ff || rsp_ready, "result overwritten")
   `TCF_ASSERT_NEXT(a_commit_shows_result, clock, reset, cmd.op == OP_RATE_OUT, rsp_valid_ff && req_ready, "result not presented")
   `TCF_ASSERT_IMPLY(a_result_from_commit, clock, reset, $rose(rsp_valid_ff), $past(cmd.op == OP_RATE_OUT), "spurious result")

endmodule

### sv/tilt_complementary_filter.sv
// ----------------------------------------------------------------------------
// Tilt complementary filter
// Blends gyro-integrated angle and rate with measured values, Q16.16.
// ----------------------------------------------------------------------------
// Each request carries one sample and gives one response. A new request is
// taken only once the previous sample has gone through every step, and the
// last step waits while an older response is still unread; the pace is set by
// the single 18x35 multiplier, used in turn for period*rate, the angle blend,
// period*accel and the rate blend. The response sits in its own register, so
// a new request is taken while the previous response still waits. The
// register channel is always ready; write it only while the filter is idle.
module tilt_complementary_filter import tcf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tcf_req_if.sink   req_ch,
   tcf_rsp_if.source rsp_ch,
   tcf_csr_if.sink   csr_ch
);

   tcf_cmd_type cmd;
   logic        req_ready;
   logic        rsp_valid;

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;
   assign csr_ch.ready = 1'b1;

   tcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   tcf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .angle_in  (req_ch.angle_in),
      .rate_in   (req_ch.rate_in),
      .accel_in  (req_ch.accel_in),
      .csr_wr    (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .angle_out (rsp_ch.angle_out),
      .rate_out  (rsp_ch.rate_out)
   );

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Tilt complementary filter regression bench
// Drives sensor samples and register writes into the filter, predicts the
// filtered angle and rate for every accepted request, and compares each
// response field by field. A directed table is run first, then randomised
// phases with varying settings and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import tcf_pkg::*;

   localparam int SETTLE_CYCLES   = 16;
   localparam int STALL_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int MAX_GAP         = 12;
   localparam int PHASE_COUNT     = 9;
   localparam int PHASE_ITEMS     = 48;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 4'hF;

   localparam longint Q31_MAX = 64'sd2147483647;
   localparam longint Q31_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [Q_W-1:0] angle;
      logic signed [Q_W-1:0] rate;
      logic signed [Q_W-1:0] accel;
   } tilt_sample_type;

   typedef struct packed {
      logic signed [Q_W-1:0] angle;
      logic signed [Q_W-1:0] rate;
   } tilt_out_type;

   typedef enum logic {
      STEP_SAMPLE,
      STEP_REG_WRITE
   } plan_kind_type;

   typedef struct {
      plan_kind_type         kind;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_data;
      tilt_sample_type       smp;
      bit                    typed;
      tilt_out_type          want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   tcf_req_if req_bus ();
   tcf_rsp_if rsp_bus ();
   tcf_csr_if csr_bus ();

   tilt_complementary_filter u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // filter model state
   logic [ALPHA_W-1:0]    cfg_alpha  = ALPHA_RESET;
   logic [PERIOD_W-1:0]   cfg_period = PERIOD_RESET;
   logic signed [Q_W-1:0] flt_angle  = '0;
   logic signed [Q_W-1:0] flt_gyro   = '0;
   logic signed [Q_W-1:0] flt_integ  = '0;
   logic signed [Q_W-1:0] flt_rate   = '0;
   bit                    flt_seed   = 1'b1;

   tilt_out_type tilt_due[$];
   plan_row_type directed_plan[$];

   bit           offer_typed = 1'b0;
   tilt_out_type offer_want  = '0;
   bit           send_idle   = 1'b0;
   bit           recv_idle   = 1'b0;
   int           rsp_hold_cycles = 0;
   int           fault_count = 0;
   int           idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint wide(logic signed [Q_W-1:0] v);
      return longint'(v);
   endfunction

   // nearest, ties towards plus infinity
   function automatic longint round_q16(longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   function automatic longint clamp_q31(longint x);
      if (x > Q31_MAX) return Q31_MAX;
      if (x < Q31_MIN) return Q31_MIN;
      return x;
   endfunction

   function automatic longint blend_q16(longint w, longint s, longint x);
      return clamp_q31(round_q16(w * s + (longint'(ALPHA_ONE) - w) * x));
   endfunction

   function automatic tilt_out_type tilt_filter_step(tilt_sample_type s);
      longint       w;
      longint       p;
      longint       integ;
      tilt_out_type o;
      w = (cfg_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(cfg_alpha);
      p = longint'(cfg_period);
      if (flt_seed) begin
         flt_seed  = 1'b0;
         flt_angle = s.angle;
         flt_gyro  = s.rate;
         flt_integ = s.rate;
         flt_rate  = s.rate;
      end
      o.angle = Q_W'(blend_q16(w, wide(flt_angle) + round_q16(p * wide(s.rate)),
                               wide(s.angle)));
      integ = clamp_q31(wide(flt_integ) + round_q16(p * wide(s.accel)));
      o.rate = Q_W'(blend_q16(w, wide(flt_rate) + wide(s.rate) + wide(flt_gyro), integ));
      flt_angle = o.angle;
      flt_integ = Q_W'(integ);
      flt_gyro  = s.rate;
      flt_rate  = o.rate;
      return o;
   endfunction

   function automatic void note_fault(string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
   endfunction

   function automatic logic signed [Q_W-1:0] draw_q16();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh7FFF_FFFF;
               1:       return 32'sh8000_0000;
               2:       return '0;
               default: return -32'sd1;
            endcase
         end
         1, 2, 3: return $urandom;
         default: return Q_W'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      endcase
   endfunction

   function automatic void plan_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      plan_row_type row;
      row = '{kind: STEP_REG_WRITE, reg_idx: idx, reg_data: data, smp: '0, typed: 1'b0,
              want: '0};
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_sample(logic signed [Q_W-1:0] a, logic signed [Q_W-1:0] r,
                                       logic signed [Q_W-1:0] c, bit typed = 1'b0,
                                       logic signed [Q_W-1:0] wa = '0,
                                       logic signed [Q_W-1:0] wr = '0);
      plan_row_type row;
      row.kind     = STEP_SAMPLE;
      row.reg_idx  = '0;
      row.reg_data = '0;
      row.smp      = {a, r, c};
      row.typed    = typed;
      row.want     = {wa, wr};
      directed_plan.push_back(row);
   endfunction

   // all calls below start and end on a falling edge
   task automatic offer_sample(tilt_sample_type s, bit typed, tilt_out_type want);
      int gap;
      gap = send_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.angle_in <= s.angle;
      req_bus.rate_in  <= s.rate;
      req_bus.accel_in <= s.accel;
      offer_typed = typed;
      offer_want  = want;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (tilt_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      tilt_sample_type taken;
      tilt_out_type    want;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_BLEND_ALPHA:   cfg_alpha  = csr_bus.data[ALPHA_W-1:0];
               CSR_SAMPLE_PERIOD: cfg_period = csr_bus.data[PERIOD_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            taken = {req_bus.angle_in, req_bus.rate_in, req_bus.accel_in};
            want  = tilt_filter_step(taken);
            if (offer_typed) want = offer_want;
            tilt_due.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (tilt_due.size() == 0) begin
               note_fault($sformatf("unexpected response: angle %h rate %h",
                                    rsp_bus.angle_out, rsp_bus.rate_out));
            end else begin
               want = tilt_due.pop_front();
               if (rsp_bus.angle_out !== want.angle)
                  note_fault($sformatf("angle_out: expected %h, got %h",
                                       want.angle, rsp_bus.angle_out));
               if (rsp_bus.rate_out !== want.rate)
                  note_fault($sformatf("rate_out: expected %h, got %h",
                                       want.rate, rsp_bus.rate_out));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tilt_complementary_filter regression: fail");
            $finish;
         end
      end
   end

   // response side
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         stall = recv_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] data;
      logic [ALPHA_W-1:0]    alpha;
      logic [PERIOD_W-1:0]   period;
      tilt_sample_type       s;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.angle_in = '0;
      req_bus.rate_in  = '0;
      req_bus.accel_in = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = '0;
      csr_bus.data     = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // first sample seeds the history
      plan_sample(32'sh0010_0000, 32'sh0003_0000, '0);
      // alpha zero, period zero: angle passes through, rate holds the integrated term
      plan_write(CSR_BLEND_ALPHA, '0);
      plan_write(CSR_SAMPLE_PERIOD, '0);
      plan_sample(32'sh7FFF_FFFF, '0, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, 32'sh0003_0000);
      plan_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1,
                  32'sh8000_0000, 32'sh0003_0000);
      plan_sample('0, '0, '0, 1'b1, '0, 32'sh0003_0000);
      // alpha one: angle holds, rate sum saturates
      plan_write(CSR_BLEND_ALPHA, CSR_DATA_W'(ALPHA_ONE));
      plan_sample(32'sh1234_5678, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, '0, 32'sh7FFF_FFFF);
      plan_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, '0, 32'sh7FFF_FFFE);
      plan_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1, '0, 32'sh8000_0000);
      // alpha above one acts as one
      plan_write(CSR_BLEND_ALPHA, 32'hFFFF_FFFF);
      plan_sample(32'sh5555_5555, '0, '0, 1'b1, '0, 32'sh8000_0000);
      plan_sample(32'shAAAA_AAAA, 32'sd1, '0, 1'b1, '0, 32'sh8000_0001);
      // unmapped register write is dropped
      plan_write(CSR_UNMAPPED, 32'h0000_8000);
      plan_sample('0, 32'sh0001_0000, '0, 1'b1, '0, 32'sh8001_0002);
      // integrated rate saturation with upper data bits set
      plan_write(CSR_BLEND_ALPHA, 32'hFFFE_0000);
      plan_write(CSR_SAMPLE_PERIOD, 32'hABCD_FFFF);
      plan_sample('0, '0, 32'sh7FFF_FFFF);
      plan_sample('0, '0, 32'sh7FFF_FFFF);
      plan_sample('0, '0, 32'sh8000_0000);
      plan_sample('0, '0, 32'sh8000_0000);
      plan_write(CSR_BLEND_ALPHA, 32'h0000_8000);
      plan_write(CSR_SAMPLE_PERIOD, 32'h0000_0001);
      plan_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      plan_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      plan_sample(-32'sd1, 32'sh0000_8000, 32'shFFFF_8000);
      plan_write(CSR_BLEND_ALPHA, CSR_DATA_W'(ALPHA_RESET));
      plan_write(CSR_SAMPLE_PERIOD, CSR_DATA_W'(PERIOD_RESET));
      plan_sample(32'sh0001_0000, 32'shFFFF_0000, '0);
      plan_sample(32'shFFFF_8000, 32'sd1, -32'sd1);
      plan_sample(32'sh00B4_0000, 32'sh0020_0000, 32'shFFE0_0000);

      send_idle = 1'b1;
      recv_idle = 1'b1;
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == STEP_REG_WRITE) begin
            wait_idle();
            write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_data);
         end else begin
            offer_sample(directed_plan[i].smp, directed_plan[i].typed, directed_plan[i].want);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         case ($urandom_range(0, 5))
            0:       alpha = '0;
            1:       alpha = ALPHA_ONE;
            2:       alpha = ALPHA_W'($urandom_range(ALPHA_ONE + 1, (1 << ALPHA_W) - 1));
            3:       alpha = ALPHA_RESET;
            default: alpha = ALPHA_W'($urandom_range(0, ALPHA_ONE));
         endcase
         case ($urandom_range(0, 4))
            0:       period = '0;
            1:       period = '1;
            2:       period = PERIOD_RESET;
            default: period = PERIOD_W'($urandom);
         endcase
         data = $urandom;
         data[ALPHA_W-1:0] = alpha;
         write_reg(CSR_BLEND_ALPHA, data);
         data = $urandom;
         data[PERIOD_W-1:0] = period;
         write_reg(CSR_SAMPLE_PERIOD, data);
         if ($urandom_range(0, 2) == 0)
            write_reg(CSR_IDX_W'($urandom_range(CSR_SAMPLE_PERIOD + 1, CSR_UNMAPPED)), $urandom);

         send_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
         recv_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
         if (phase == 2) begin
            send_idle = 1'b0;
            rsp_hold_cycles = HOLD_OFF_CYCLES;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 47) == 0) wait_idle();
            s = {draw_q16(), draw_q16(), draw_q16()};
            offer_sample(s, 1'b0, '0);
         end
      end

      wait_idle();
      if (tilt_due.size() != 0)
         note_fault($sformatf("%0d responses never arrived", tilt_due.size()));
      if (fault_count == 0) begin
         $display("tilt_complementary_filter regression: pass");
      end else begin
         $display("tilt_complementary_filter regression: fail");
      end
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/tcf_pkg.sv
sv/tcf_req_if.sv
sv/tcf_rsp_if.sv
sv/tcf_csr_if.sv
sv/tcf_datapath.sv
sv/tcf_ctrl.sv
sv/tilt_complementary_filter.sv
tb/sv/tb_top.sv
